// ===== rtl/core/rtpc_pkg.sv =====
package rtpc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int COORD_BITS  = 12;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);

  localparam int IDX_IN_W  = 10;
  localparam int VAL_W     = 24;
  localparam int PIX_W     = 16;
  localparam int CX_W      = 18;
  localparam int INV_W     = 24;
  localparam int RC_W      = 11;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam int FR_W     = 16;
  localparam int RID_W    = TIDX_W + FR_W;
  localparam int DX_W     = ((COORD_BITS + 5 > CX_W) ? COORD_BITS + 5 : CX_W) + 1;
  localparam int SQ_W     = 2 * DX_W;
  localparam int RAD_W    = SQ_W + FR_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int PROD_W   = ROOT_W + INV_W;
  localparam int SCALE_SH = 12;

  localparam int PC_W = VAL_W + FR_W + 2;
  localparam int C_W  = PC_W + 1;
  localparam int D_W  = C_W + 2;
  localparam int QSH  = 24;

  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_COL  = 2'd0,
    CFG_ORIGIN_ROW  = 2'd1,
    CFG_INV_SPACING = 2'd2,
    CFG_RING_COUNT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CX_W-1:0] origin_col;
    logic signed [CX_W-1:0] origin_row;
    logic [INV_W-1:0]       inv;
    logic [TIDX_W-1:0]      last_ring;
  } cfg_t;

  typedef struct packed {
    logic                    is_pix;
    logic                    wr_en;
    logic signed [PIX_W-1:0] pix;
    logic [TIDX_W-1:0]       widx;
    logic signed [VAL_W-1:0] wval;
  } item_meta_t;

  typedef struct packed {
    item_meta_t        meta;
    logic [RID_W-1:0]  rid;
  } mid_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] value;
    logic                    sat;
  } result_t;

endpackage

// ===== rtl/core/rtpc_front.sv =====
module rtpc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtpc_pkg::cfg_t                      cfg,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_req_type,
  input  logic [rtpc_pkg::IDX_IN_W-1:0]       in_table_index,
  input  logic signed [rtpc_pkg::VAL_W-1:0]   in_table_value,
  input  logic [rtpc_pkg::COORD_BITS-1:0]     in_pixel_col,
  input  logic [rtpc_pkg::COORD_BITS-1:0]     in_pixel_row,
  input  logic signed [rtpc_pkg::PIX_W-1:0]   in_pixel_value,
  output logic                                mid_push,
  output rtpc_pkg::mid_item_t                 mid_item,
  input  logic                                mid_full
);
  import rtpc_pkg::*;

  localparam int NSTG = ROOT_W + 5;

  typedef struct packed {
    logic [ROOT_W:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] bits);
    logic [ROOT_W+2:0] acc;
    logic [ROOT_W+2:0] trial;
    sqrt_t             nxt;
    acc   = {cur.rem, bits};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      nxt.rem  = (ROOT_W + 1)'(acc - trial);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = (ROOT_W + 1)'(acc);
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [NSTG-1:0]          v_r;
  item_meta_t               meta_r [NSTG];
  logic signed [DX_W-1:0]   dx_r, dy_r;
  logic signed [SQ_W-1:0]   sqx_r, sqy_r;
  logic [SQ_W-1:0]          r2_r;
  sqrt_t                    sq_r [ROOT_W];
  logic [RAD_W-1:0]         rad_r [ROOT_W-1];
  logic [PROD_W-1:0]        prod_r;
  logic [RID_W-1:0]         rid_r;

  logic                     front_en;
  item_meta_t               meta_in;
  logic signed [DX_W-1:0]   dx_nxt, dy_nxt;
  logic [RAD_W-1:0]         r2_rad;
  logic [PROD_W-SCALE_SH-1:0] scaled;
  logic [RID_W-1:0]         rmax;
  logic [RID_W-1:0]         rid_nxt;

  assign front_en = !(v_r[NSTG-1] && mid_full);
  assign in_full  = !front_en;
  assign mid_push = v_r[NSTG-1] && front_en;
  assign mid_item = '{meta: meta_r[NSTG-1], rid: rid_r};

  always_comb begin
    meta_in.is_pix = in_req_type;
    meta_in.wr_en  = !in_req_type && (32'(in_table_index) < TABLE_DEPTH);
    meta_in.pix    = in_pixel_value;
    meta_in.widx   = TIDX_W'(in_table_index);
    meta_in.wval   = in_table_value;
    dx_nxt = DX_W'($signed({1'b0, in_pixel_col, 4'b0000})) - DX_W'(cfg.origin_col);
    dy_nxt = DX_W'($signed({1'b0, in_pixel_row, 4'b0000})) - DX_W'(cfg.origin_row);
    r2_rad = {r2_r, {FR_W{1'b0}}};
    scaled = prod_r[PROD_W-1:SCALE_SH];
    rmax   = {cfg.last_ring, {FR_W{1'b0}}};
    if (scaled > (PROD_W - SCALE_SH)'(rmax)) begin
      rid_nxt = rmax;
    end else begin
      rid_nxt = scaled[RID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (front_en) begin
      v_r <= {v_r[NSTG-2:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      meta_r[0] <= meta_in;
      for (int i = 1; i < NSTG; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
      sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
      r2_r  <= $unsigned(sqx_r) + $unsigned(sqy_r);
      sq_r[0]  <= sqrt_step('0, r2_rad[RAD_W-1 -: 2]);
      rad_r[0] <= r2_rad << 2;
      for (int k = 1; k < ROOT_W; k++) begin
        sq_r[k] <= sqrt_step(sq_r[k-1], rad_r[k-1][RAD_W-1 -: 2]);
      end
      for (int k = 1; k < ROOT_W - 1; k++) begin
        rad_r[k] <= rad_r[k-1] << 2;
      end
      prod_r <= PROD_W'(sq_r[ROOT_W-1].root) * PROD_W'(cfg.inv);
      rid_r  <= rid_nxt;
    end
  end

endmodule

// ===== rtl/core/rtpc_queue.sv =====
module rtpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rtpc_pkg::mid_item_t push_item,
  output logic                full,
  input  logic                pop,
  output rtpc_pkg::mid_item_t pop_item,
  output logic                empty
);
  import rtpc_pkg::*;

  mid_item_t              mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0]   wp_r, rp_r;
  logic [MID_PTR_W:0]     cnt_r, cnt_nxt;
  logic                   do_push, do_pop;

  assign full     = (cnt_r == (MID_PTR_W + 1)'(MID_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/rtpc_back.sv =====
module rtpc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rtpc_pkg::mid_item_t               mid_item,
  input  logic                              mid_empty,
  output logic                              mid_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [rtpc_pkg::PIX_W-1:0] out_corrected_value,
  output logic                              out_saturated
);
  import rtpc_pkg::*;

  localparam logic signed [D_W-1:0] BIAS = D_W'((1 << QSH) - 1);

  logic signed [VAL_W-1:0] tbl_r [TABLE_DEPTH];

  logic [3:0]              bv_r;
  logic signed [PIX_W-1:0] pix_r [3];
  logic signed [VAL_W-1:0] rda_r, rdb_r;
  logic [FR_W-1:0]         fr_r;
  logic signed [PC_W-1:0]  pa_r, pb_r;
  logic signed [C_W-1:0]   c_r;
  logic signed [D_W-1:0]   d_r;

  result_t                 out_mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]    owp_r, orp_r;
  logic [OUT_PTR_W:0]      ocnt_r, ocnt_nxt;

  logic                    back_en;
  logic                    out_full;
  logic                    res_push;
  logic                    res_pop;
  logic [TIDX_W-1:0]       rd_f, rd_f1;
  logic [FR_W:0]           wa;
  logic signed [D_W-1:0]   qb, qf;
  result_t                 res;

  assign out_full = (ocnt_r == (OUT_PTR_W + 1)'(OUT_DEPTH));
  assign back_en  = !(bv_r[3] && out_full);
  assign mid_pop  = back_en && !mid_empty;
  assign res_push = bv_r[3] && !out_full;
  assign out_empty = (ocnt_r == '0);
  assign res_pop   = out_pop && !out_empty;
  assign out_corrected_value = out_mem_r[orp_r].value;
  assign out_saturated       = out_mem_r[orp_r].sat;

  always_comb begin
    rd_f  = mid_item.rid[RID_W-1:FR_W];
    rd_f1 = rd_f + 1'b1;
    wa    = {1'b1, {FR_W{1'b0}}} - {1'b0, fr_r};
    qb    = d_r[D_W-1] ? d_r + BIAS : d_r;
    qf    = qb >>> QSH;
    res.sat = 1'b0;
    if (qf > D_W'(32767)) begin
      res.value = 16'sh7fff;
      res.sat   = 1'b1;
    end else if (qf < -D_W'(32768)) begin
      res.value = -16'sh8000;
      res.sat   = 1'b1;
    end else begin
      res.value = PIX_W'(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      if (mid_pop && mid_item.meta.wr_en) begin
        tbl_r[mid_item.meta.widx] <= mid_item.meta.wval;
      end
      rda_r <= tbl_r[rd_f];
      rdb_r <= tbl_r[rd_f1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (back_en) begin
      bv_r <= {bv_r[2:0], mid_pop && mid_item.meta.is_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      fr_r     <= mid_item.rid[FR_W-1:0];
      pix_r[0] <= mid_item.meta.pix;
      pix_r[1] <= pix_r[0];
      pix_r[2] <= pix_r[1];
      pa_r     <= rda_r * $signed({1'b0, wa});
      if (fr_r == '0) begin
        pb_r <= '0;
      end else begin
        pb_r <= rdb_r * $signed({2'b00, fr_r});
      end
      c_r <= C_W'(pa_r) + C_W'(pb_r);
      d_r <= D_W'($signed({pix_r[2], {QSH{1'b0}}})) - D_W'(c_r);
    end
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_push && !res_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (res_pop && !res_push) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (res_push) begin
        owp_r <= owp_r + 1'b1;
      end
      if (res_pop) begin
        orp_r <= orp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_mem_r[owp_r] <= res;
    end
  end

endmodule

// ===== rtl/core/radial_table_pixel_correction_top.sv =====
// Datapath: a pixel passes the 27-stage square root pipeline in the front part, then the
// table read and interpolation in the back part, before its result shows.
// Throughput: one transaction per cycle while in_full is low, table writes included; table writes give no result.
// Reset: synchronous, active low; clears all queues and pipeline valids and loads the
// register defaults. The correction table is not cleared and must be written before use.
module radial_table_pixel_correction_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic [rtpc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rtpc_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_req_type,
  input  logic [rtpc_pkg::IDX_IN_W-1:0]         in_table_index,
  input  logic signed [rtpc_pkg::VAL_W-1:0]     in_table_value,
  input  logic [rtpc_pkg::COORD_BITS-1:0]       in_pixel_col,
  input  logic [rtpc_pkg::COORD_BITS-1:0]       in_pixel_row,
  input  logic signed [rtpc_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [rtpc_pkg::PIX_W-1:0]     out_corrected_value,
  output logic                                  out_saturated
);
  import rtpc_pkg::*;

  logic signed [CX_W-1:0] origin_col_r, origin_row_r;
  logic [INV_W-1:0]       inv_r;
  logic [RC_W-1:0]        ring_count_r;
  logic [TIDX_W-1:0]      last_ring;
  cfg_t                   cfg;

  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_item_t mid_in, mid_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_col_r <= '0;
      origin_row_r <= '0;
      inv_r        <= INV_W'(65536);
      ring_count_r <= RC_W'(1024);
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ORIGIN_COL:  origin_col_r <= $signed(cfg_data[CX_W-1:0]);
        CFG_ORIGIN_ROW:  origin_row_r <= $signed(cfg_data[CX_W-1:0]);
        CFG_INV_SPACING: inv_r        <= cfg_data[INV_W-1:0];
        CFG_RING_COUNT:  ring_count_r <= cfg_data[RC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (ring_count_r == '0) begin
      last_ring = '0;
    end else if (32'(ring_count_r) > TABLE_DEPTH) begin
      last_ring = TIDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_ring = TIDX_W'(ring_count_r - 1'b1);
    end
    cfg.origin_col = origin_col_r;
    cfg.origin_row = origin_row_r;
    cfg.inv        = inv_r;
    cfg.last_ring  = last_ring;
  end

  rtpc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_value (in_pixel_value),
    .mid_push       (mid_push),
    .mid_item       (mid_in),
    .mid_full       (mid_full)
  );

  rtpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_item (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_item  (mid_out),
    .empty     (mid_empty)
  );

  rtpc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .mid_item            (mid_out),
    .mid_empty           (mid_empty),
    .mid_pop             (mid_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_corrected_value (out_corrected_value),
    .out_saturated       (out_saturated)
  );

endmodule

// ===== rtl/core/rtpc_checker.sv =====
module rtpc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_full,
  input logic                                  out_empty,
  input logic                                  out_pop,
  input logic signed [rtpc_pkg::PIX_W-1:0]     out_corrected_value,
  input logic                                  out_saturated
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_corrected_value) && $stable(out_saturated)))
    else $error("waiting result changed");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_saturated) |->
      (out_corrected_value == 16'sh7fff || out_corrected_value == -16'sh8000))
    else $error("saturated flag without a limit value");

endmodule

bind radial_table_pixel_correction_top rtpc_checker u_rtpc_checker (.*);

// ===== tb/radial_table_pixel_correction_checker.sv =====
module radial_table_pixel_correction_checker
  import rtpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_push,
  input  logic                     in_full,
  input  logic                     in_req_type,
  input  logic [IDX_IN_W-1:0]      in_table_index,
  input  logic signed [VAL_W-1:0]  in_table_value,
  input  logic [COORD_BITS-1:0]    in_pixel_col,
  input  logic [COORD_BITS-1:0]    in_pixel_row,
  input  logic signed [PIX_W-1:0]  in_pixel_value,
  input  logic                     out_empty,
  input  logic                     out_pop,
  input  logic signed [PIX_W-1:0]  out_corrected_value,
  input  logic                     out_saturated,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [CX_W-1:0]  ring_centre_x;
  logic signed [CX_W-1:0]  ring_centre_y;
  logic [INV_W-1:0]        spacing_recip;
  logic [RC_W-1:0]         rings;
  logic signed [VAL_W-1:0] corr_table [TABLE_DEPTH];
  result_t                 expected_pixels [$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic result_t correct_pixel(logic [COORD_BITS-1:0] col,
                                            logic [COORD_BITS-1:0] row,
                                            logic signed [PIX_W-1:0] pix);
    longint          dx, dy, c, d, q;
    longint unsigned r2, radius, rid, rmax, n, f, fr;
    result_t         r;
    dx = longint'(col) * 16 - longint'(ring_centre_x);
    dy = longint'(row) * 16 - longint'(ring_centre_y);
    r2 = longint'(dx * dx) + longint'(dy * dy);
    radius = int_sqrt(r2 << 16);
    rid = (radius * longint'(spacing_recip)) >> 12;
    n = rings;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    rmax = (n - 1) << 16;
    if (rid > rmax) rid = rmax;
    f  = rid >> 16;
    fr = rid & 64'hFFFF;
    if (fr == 0) begin
      c = longint'(corr_table[f]) * 65536;
    end else begin
      c = longint'(corr_table[f]) * longint'(65536 - fr)
        + longint'(corr_table[f + 1]) * longint'(fr);
    end
    d = longint'(pix) * 16777216 - c;
    q = d / 16777216;
    r.sat = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.sat = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.sat = 1'b1;
    end
    r.value = q[PIX_W-1:0];
    return r;
  endfunction

  assign pending = expected_pixels.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      ring_centre_x = '0;
      ring_centre_y = '0;
      spacing_recip = 24'd65536;
      rings         = 11'd1024;
      expected_pixels.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORIGIN_COL:  ring_centre_x = cfg_data[CX_W-1:0];
          CFG_ORIGIN_ROW:  ring_centre_y = cfg_data[CX_W-1:0];
          CFG_INV_SPACING: spacing_recip = cfg_data[INV_W-1:0];
          CFG_RING_COUNT:  rings = cfg_data[RC_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_req_type) begin
          expected_pixels.insert(expected_pixels.size(),
                                 correct_pixel(in_pixel_col, in_pixel_row, in_pixel_value));
        end else if (in_table_index < TABLE_DEPTH) begin
          corr_table[in_table_index] = in_table_value;
        end
      end
      if (out_pop && !out_empty) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction: corrected_value %0d", out_corrected_value);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_corrected_value !== want.value) begin
            $error("corrected_value expected %0d actual %0d", want.value, out_corrected_value);
            fail_count++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated expected %0d actual %0d", want.sat, out_saturated);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_radial_table_pixel_correction_top.sv =====
module tb_radial_table_pixel_correction_top;
  import rtpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_write_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_push;
  logic                    in_full;
  logic                    in_req_type;
  logic [IDX_IN_W-1:0]     in_table_index;
  logic signed [VAL_W-1:0] in_table_value;
  logic [COORD_BITS-1:0]   in_pixel_col;
  logic [COORD_BITS-1:0]   in_pixel_row;
  logic signed [PIX_W-1:0] in_pixel_value;
  logic                    out_empty;
  logic                    out_pop;
  logic signed [PIX_W-1:0] out_corrected_value;
  logic                    out_saturated;
  int                      fail_count;
  int                      pending;
  int                      cycles;
  int                      burst_left;
  bit                      hold_off;

  radial_table_pixel_correction_top u_dut (.*);

  radial_table_pixel_correction_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver switches at random among four pop patterns; a hold-off stops it outright.
  initial begin
    int mode;
    int hold;
    out_pop = 1'b0;
    mode    = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_pop = 1'b0;
        for (hold = 0; hold < 300; hold++) @(negedge clk);
        hold_off = 1'b0;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_pop = 1'b1;
        1:       out_pop = ($urandom_range(0, 1) == 1);
        2:       out_pop = ($urandom_range(0, 9) == 0);
        default: out_pop = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  task automatic set_rings(int cx, int cy, int inv, int rc);
    @(negedge clk);
    in_push = 1'b0;
    burst_left = 0;
    wait (pending == 0);
    repeat (45) @(posedge clk);
    write_reg(CFG_ORIGIN_COL, CFG_W'(cx));
    write_reg(CFG_ORIGIN_ROW, CFG_W'(cy));
    write_reg(CFG_INV_SPACING, CFG_W'(inv));
    write_reg(CFG_RING_COUNT, CFG_W'(rc));
  endtask

  task automatic offer_item(bit is_pixel, int idx, int val, int col, int row, int pix);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_push        = 1'b1;
    in_req_type    = is_pixel;
    in_table_index = IDX_IN_W'(idx);
    in_table_value = VAL_W'(val);
    in_pixel_col   = COORD_BITS'(col);
    in_pixel_row   = COORD_BITS'(row);
    in_pixel_value = PIX_W'(pix);
    do @(posedge clk); while (in_full);
  endtask

  task automatic load_entry(int idx, int val);
    offer_item(1'b0, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic correct_at(int col, int row, int pix);
    offer_item(1'b1, $urandom, $urandom, col, row, pix);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int pick_table_value();
    case ($urandom_range(0, 7))
      0:       return -8388608;
      1:       return 8388607;
      2:       return $urandom_range(0, 2000) - 1000;
      3:       return $urandom_range(0, 200000) - 100000;
      default: return $urandom_range(0, 16777215) - 8388608;
    endcase
  endfunction

  function automatic int pick_pixel_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  task automatic random_run(int count, bit with_hold);
    int k;
    for (k = 0; k < count; k++) begin
      if (with_hold && k == count / 3) hold_off = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        load_entry($urandom_range(0, 1023), pick_table_value());
      end else begin
        correct_at(pick_coord(), pick_coord(), pick_pixel_value());
      end
    end
  endtask

  initial begin
    int k;
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_index      = CFG_ORIGIN_COL;
    cfg_data       = '0;
    in_push        = 1'b0;
    in_req_type    = 1'b0;
    in_table_index = '0;
    in_table_value = '0;
    in_pixel_col   = '0;
    in_pixel_row   = '0;
    in_pixel_value = '0;
    burst_left     = 0;
    hold_off       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // With a single ring every pixel uses entry 0 only, so no unwritten entry affects a result.
    set_rings(0, 0, 65536, 1);
    load_entry(0, 8388607);
    correct_at(0, 0, -32768);
    correct_at(4095, 4095, 32767);
    load_entry(0, -8388608);
    correct_at(4095, 0, 32767);
    correct_at(0, 4095, -32768);
    load_entry(0, 1);
    correct_at(17, 33, 0);
    load_entry(0, -1);
    correct_at(5, 5, 0);
    load_entry(0, 0);
    correct_at(100, 200, -32768);
    correct_at(100, 200, 32767);

    for (k = 0; k < TABLE_DEPTH; k++) load_entry(k, pick_table_value());

    set_rings(0, 0, 65536, 1024);
    correct_at(3, 4, 1000);
    correct_at(0, 0, -5);
    correct_at(4095, 4095, 12);
    correct_at(1, 1, 77);
    load_entry(1023, 8388607);
    correct_at(4095, 4095, -32768);

    random_run(130, 1'b1);
    set_rings(-65536, 131071, 16777215, 1024);
    random_run(110, 1'b0);
    set_rings(131071, -65536, 1, 2047);
    random_run(110, 1'b0);
    set_rings($urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
    random_run(90, 1'b0);
    set_rings($urandom_range(0, 65535), $urandom_range(0, 65535), 1 << 20, 2);
    random_run(110, 1'b1);
    set_rings(32768, 32768, $urandom_range(4096, 262143), $urandom_range(1, 1024));
    random_run(130, 1'b0);
    set_rings($urandom_range(0, 196607) - 65536, $urandom_range(0, 196607) - 65536,
              $urandom_range(1, 16777215), $urandom_range(0, 2047));
    random_run(130, 1'b0);

    @(negedge clk);
    in_push = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== radial_table_pixel_correction_top.f =====
rtl/core/rtpc_pkg.sv
rtl/core/rtpc_front.sv
rtl/core/rtpc_queue.sv
rtl/core/rtpc_back.sv
rtl/core/radial_table_pixel_correction_top.sv
rtl/core/rtpc_checker.sv
tb/radial_table_pixel_correction_checker.sv
tb/tb_radial_table_pixel_correction_top.sv
